>>> src/srfc_pkg.sv
`timescale 1ns / 1ps
package srfc_pkg;

  localparam int IN_W      = 24;
  localparam int PIECE_W   = 26;
  localparam int COLOR_W   = 32;
  localparam int LOGIC_W   = 14;
  localparam int SCALE_W   = 16;
  localparam int SCALE_FRAC = 8;
  localparam int START_W   = 26;
  localparam int STRIDE_W  = 14;
  localparam int CNT_W     = 14;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [SCALE_W-1:0] SCALE_ONE      = 16'd256;
  localparam logic [LOGIC_W-1:0] RST_LOG_WIDTH  = 14'd640;
  localparam logic [LOGIC_W-1:0] RST_LOG_HEIGHT = 14'd480;
  localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd256;

  typedef enum logic [1:0] {
    REG_LOGICAL_WIDTH  = 2'd0,
    REG_LOGICAL_HEIGHT = 2'd1,
    REG_SCALE_FACTOR   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PIECE_TOP    = 2'd0,
    PIECE_BOTTOM = 2'd1,
    PIECE_LEFT   = 2'd2,
    PIECE_RIGHT  = 2'd3
  } piece_t;

  typedef enum logic {
    OP_FILL   = 1'b0,
    OP_STROKE = 1'b1
  } op_t;

  typedef struct packed {
    logic                      op;
    logic signed [IN_W-1:0]    left;
    logic signed [IN_W-1:0]    top;
    logic signed [IN_W-1:0]    span_w;
    logic signed [IN_W-1:0]    span_h;
    logic signed [IN_W-1:0]    stroke_w;
    logic [COLOR_W-1:0]        fill_color;
  } draw_req_t;

  typedef struct packed {
    logic [START_W-1:0]  start_index;
    logic [STRIDE_W-1:0] row_stride;
    logic [CNT_W-1:0]    columns;
    logic [CNT_W-1:0]    rows;
    logic [COLOR_W-1:0]  color_out;
    logic                last;
  } fill_req_t;

  // Sideband that rides with each band through the clip pipeline.
  typedef struct packed {
    logic               kill;
    logic               cmd_end;
    logic [COLOR_W-1:0] color;
  } tag_t;

endpackage

>>> src/srfc_if.sv
`timescale 1ns / 1ps
interface srfc_draw_if;
  logic                valid;
  logic                ready;
  srfc_pkg::draw_req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface srfc_fill_if;
  logic                valid;
  logic                ready;
  srfc_pkg::fill_req_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> src/scaled_rect_fill_stroke_clipper_unit.sv
`timescale 1ns / 1ps
// Scaled rectangle clipper: takes fill or stroke rectangle requests in signed
// Q15.8 logical units, scales them by the Q8.8 scale register (zero acts as
// 1.0), clips them to the physical canvas and truncates to whole pixels, then
// sends each non-empty piece downstream as one fill request (start index,
// stride, columns, rows, color), with last set on the final one of a request.
// A fill request is a single band; a stroke is two bands (top and bottom) or
// four (plus left and right bands when the height exceeds twice the line
// width), and a degenerate stroke is one band that is dropped. The band
// sequencer takes the next request as the last band issues, and issues one
// band per cycle while the clip pipeline is not stalled; the output port
// carries one fill request per cycle while the receiver is ready. Bands flow
// through a 7-stage clip pipeline (band register, multiply, add, clamp,
// truncate, row multiply, index add) followed by a one-entry hold stage that
// resolves the last flag, then the output register. Physical canvas sizes are
// recomputed in the cycle after a register write; write registers only while
// the block is idle. There are no memories and no clearing pass after reset.
module scaled_rect_fill_stroke_clipper_unit #(
  parameter int PHYS_MAX  = 8192,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  srfc_draw_if.sink                   draw,
  srfc_fill_if.source                 fill,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srfc_pkg::APB_AW-1:0] paddr,
  input  logic [srfc_pkg::APB_DW-1:0] pwdata,
  output logic [srfc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import srfc_pkg::*;

  localparam int SH    = FRAC_BITS + SCALE_FRAC;     // fraction bits of a scaled value
  localparam int SW    = SCALE_W + 1;                // scale as a signed operand
  localparam int MW    = PIECE_W + SW;               // scaled coordinate
  localparam int AW    = MW + 1;                     // scaled coordinate plus size
  localparam int PW_W  = $clog2(PHYS_MAX + 1);       // physical size in pixels
  localparam int LP_W  = LOGIC_W + SCALE_W;          // logical size times scale
  localparam int LS_W  = LP_W - SCALE_FRAC;          // after dropping scale fraction
  localparam int PR_W  = 2 * PW_W;                   // row times stride
  localparam int SUM_W = PR_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers, APB write at access phase
  // ---------------------------------------------------------------------------
  logic [LOGIC_W-1:0] logical_width;
  logic [LOGIC_W-1:0] logical_height;
  logic [SCALE_W-1:0] scale_factor;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      logical_width  <= RST_LOG_WIDTH;
      logical_height <= RST_LOG_HEIGHT;
      scale_factor   <= RST_SCALE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOGICAL_WIDTH:  logical_width  <= pwdata[LOGIC_W-1:0];
        REG_LOGICAL_HEIGHT: logical_height <= pwdata[LOGIC_W-1:0];
        REG_SCALE_FACTOR:   scale_factor   <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOGICAL_WIDTH:  prdata = APB_DW'(logical_width);
      REG_LOGICAL_HEIGHT: prdata = APB_DW'(logical_height);
      REG_SCALE_FACTOR:   prdata = APB_DW'(scale_factor);
      default:            prdata = '0;
    endcase
  end

  // Effective scale and saturated physical canvas size, refreshed every cycle.
  logic [SCALE_W-1:0]   scale_eff;
  logic signed [SW-1:0] scale_s;
  logic [LP_W-1:0]      lw_prod;
  logic [LP_W-1:0]      lh_prod;
  logic [LS_W-1:0]      lw_pix;
  logic [LS_W-1:0]      lh_pix;
  logic [PW_W-1:0]      phys_w;
  logic [PW_W-1:0]      phys_h;

  assign scale_eff = (scale_factor == '0) ? SCALE_ONE : scale_factor;
  assign scale_s   = $signed({1'b0, scale_eff});
  assign lw_prod   = LP_W'(logical_width) * LP_W'(scale_eff);
  assign lh_prod   = LP_W'(logical_height) * LP_W'(scale_eff);
  assign lw_pix    = lw_prod[LP_W-1:SCALE_FRAC];
  assign lh_pix    = lh_prod[LP_W-1:SCALE_FRAC];

  always_ff @(posedge clk) begin
    phys_w <= (lw_pix > LS_W'(PHYS_MAX)) ? PW_W'(PHYS_MAX) : PW_W'(lw_pix);
    phys_h <= (lh_pix > LS_W'(PHYS_MAX)) ? PW_W'(PHYS_MAX) : PW_W'(lh_pix);
  end

  // ---------------------------------------------------------------------------
  // Band sequencer: hold one request; unless the pipeline stalls, issue one band per cycle
  // ---------------------------------------------------------------------------
  logic       cmd_valid;
  draw_req_t  cmd;
  logic [1:0] piece_idx;
  piece_t     last_idx;
  logic       cmd_kill;

  logic       accept;
  logic       issue;
  logic       done;
  logic       load1, load2, load3, load4, load5, load6, load7;

  // Shape of the incoming request decides the band count.
  logic signed [IN_W:0] in_h2;
  logic signed [IN_W:0] in_lw2;
  logic                 in_degen;
  logic                 in_tall;
  piece_t               in_last;

  assign in_h2    = (IN_W + 1)'($signed(draw.payload.span_h));
  assign in_lw2   = $signed({draw.payload.stroke_w, 1'b0});
  assign in_degen = !(draw.payload.span_w > 0 && draw.payload.span_h > 0
                      && draw.payload.stroke_w > 0);
  assign in_tall  = in_h2 > in_lw2;

  always_comb begin
    if (op_t'(draw.payload.op) == OP_FILL || in_degen) begin
      in_last = PIECE_TOP;
    end else if (in_tall) begin
      in_last = PIECE_RIGHT;
    end else begin
      in_last = PIECE_BOTTOM;
    end
  end

  assign issue      = cmd_valid && load1;
  assign done       = issue && (piece_idx == last_idx);
  assign draw.ready = !cmd_valid || done;
  assign accept     = draw.valid && draw.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      piece_idx <= '0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
      piece_idx <= '0;
    end else if (done) begin
      cmd_valid <= 1'b0;
    end else if (issue) begin
      piece_idx <= piece_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= draw.payload;
      last_idx <= in_last;
      cmd_kill <= (op_t'(draw.payload.op) == OP_STROKE) && in_degen;
    end
  end

  // Band geometry in logical units.
  logic signed [PIECE_W-1:0] xe, ye, we, he, le;
  logic signed [PIECE_W-1:0] y_bot, y_mid, h_mid, x_right;
  logic signed [PIECE_W-1:0] bx, by, bw, bh;

  assign xe      = PIECE_W'($signed(cmd.left));
  assign ye      = PIECE_W'($signed(cmd.top));
  assign we      = PIECE_W'($signed(cmd.span_w));
  assign he      = PIECE_W'($signed(cmd.span_h));
  assign le      = PIECE_W'($signed(cmd.stroke_w));
  assign y_bot   = ye + he - le;
  assign y_mid   = ye + le;
  assign h_mid   = he - (le <<< 1);
  assign x_right = xe + we - le;

  always_comb begin
    unique case (piece_t'(piece_idx))
      PIECE_TOP: begin
        bx = xe;
        by = ye;
        bw = we;
        bh = (op_t'(cmd.op) == OP_FILL) ? he : le;
      end
      PIECE_BOTTOM: begin
        bx = xe;
        by = y_bot;
        bw = we;
        bh = le;
      end
      PIECE_LEFT: begin
        bx = xe;
        by = y_mid;
        bw = le;
        bh = h_mid;
      end
      PIECE_RIGHT: begin
        bx = x_right;
        by = y_mid;
        bw = le;
        bh = h_mid;
      end
      default: begin
        bx = xe;
        by = ye;
        bw = we;
        bh = he;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clip pipeline; each stage loads when empty or when the next one loads
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, v7;
  logic q_take;

  assign load7 = !v7 || q_take;
  assign load6 = !v6 || load7;
  assign load5 = !v5 || load6;
  assign load4 = !v4 || load5;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (load1) v1 <= cmd_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
      if (load5) v5 <= v4;
      if (load6) v6 <= v5;
      if (load7) v7 <= v6;
    end
  end

  // Stage 1: band registered
  logic signed [PIECE_W-1:0] s1_x, s1_y, s1_w, s1_h;
  tag_t                      t1;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_x       <= bx;
      s1_y       <= by;
      s1_w       <= bw;
      s1_h       <= bh;
      t1.kill    <= cmd_kill;
      t1.cmd_end <= (piece_idx == last_idx);
      t1.color   <= cmd.fill_color;
    end
  end

  // Stage 2: scale corner and size
  logic signed [MW-1:0] s2_px, s2_py, s2_dx, s2_dy;
  tag_t                 t2;

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_px <= s1_x * scale_s;
      s2_py <= s1_y * scale_s;
      s2_dx <= s1_w * scale_s;
      s2_dy <= s1_h * scale_s;
      t2    <= t1;
    end
  end

  // Stage 3: far corner, clamp near corner at zero
  logic signed [MW-1:0] s3_px, s3_py;
  logic signed [AW-1:0] s3_px2, s3_py2;
  tag_t                 t3;

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_px  <= s2_px[MW-1] ? '0 : s2_px;
      s3_py  <= s2_py[MW-1] ? '0 : s2_py;
      s3_px2 <= AW'(s2_px) + AW'(s2_dx);
      s3_py2 <= AW'(s2_py) + AW'(s2_dy);
      t3     <= t2;
    end
  end

  // Stage 4: clamp far corner to the canvas
  logic signed [AW-1:0] lim_x, lim_y;
  logic signed [MW-1:0] s4_px, s4_py;
  logic signed [AW-1:0] s4_px2, s4_py2;
  tag_t                 t4;

  assign lim_x = AW'(phys_w) << SH;
  assign lim_y = AW'(phys_h) << SH;

  always_ff @(posedge clk) begin
    if (load4) begin
      s4_px  <= s3_px;
      s4_py  <= s3_py;
      s4_px2 <= (s3_px2 > lim_x) ? lim_x : s3_px2;
      s4_py2 <= (s3_py2 > lim_y) ? lim_y : s3_py2;
      t4     <= t3;
    end
  end

  // Stage 5: truncate to pixels, flag empty bands
  logic [AW-1:0]   x1f, y1f, x2f, y2f, xdf, ydf;
  logic            empty4;
  logic            s5_empty;
  logic [PW_W-1:0] s5_x1, s5_y1, s5_cols, s5_rows;
  tag_t            t5;

  assign x1f    = $unsigned(AW'(s4_px)) >> SH;
  assign y1f    = $unsigned(AW'(s4_py)) >> SH;
  assign x2f    = $unsigned(s4_px2) >> SH;
  assign y2f    = $unsigned(s4_py2) >> SH;
  assign xdf    = x2f - x1f;
  assign ydf    = y2f - y1f;
  assign empty4 = t4.kill || s4_px2[AW-1] || s4_py2[AW-1] || (x2f <= x1f) || (y2f <= y1f);

  always_ff @(posedge clk) begin
    if (load5) begin
      s5_empty <= empty4;
      s5_x1    <= x1f[PW_W-1:0];
      s5_y1    <= y1f[PW_W-1:0];
      s5_cols  <= xdf[PW_W-1:0];
      s5_rows  <= ydf[PW_W-1:0];
      t5       <= t4;
    end
  end

  // Stage 6: row offset
  logic            s6_empty;
  logic [PR_W-1:0] s6_row_off;
  logic [PW_W-1:0] s6_x1, s6_cols, s6_rows;
  tag_t            t6;

  always_ff @(posedge clk) begin
    if (load6) begin
      s6_empty   <= s5_empty;
      s6_row_off <= PR_W'(s5_y1) * PR_W'(phys_w);
      s6_x1      <= s5_x1;
      s6_cols    <= s5_cols;
      s6_rows    <= s5_rows;
      t6         <= t5;
    end
  end

  // Stage 7: start index, fill request assembled
  logic [SUM_W-1:0] start_sum;
  logic             s7_live;
  logic             s7_end;
  fill_req_t        s7_req;

  assign start_sum = SUM_W'(s6_row_off) + SUM_W'(s6_x1);

  always_ff @(posedge clk) begin
    if (load7) begin
      s7_live            <= !s6_empty;
      s7_end             <= t6.cmd_end;
      s7_req.start_index <= START_W'(start_sum);
      s7_req.row_stride  <= STRIDE_W'(phys_w);
      s7_req.columns     <= CNT_W'(s6_cols);
      s7_req.rows        <= CNT_W'(s6_rows);
      s7_req.color_out   <= t6.color;
      s7_req.last        <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Hold stage: keep one live band back until the next live band or the end
  // of its request shows whether it is the last one
  // ---------------------------------------------------------------------------
  logic      p_valid;
  logic      p_fin;
  fill_req_t p_req;
  fill_req_t out_req;
  logic      out_free;
  logic      need_emit;
  logic      emit;
  logic      emit_last;

  assign out_free  = !fill.valid || fill.ready;
  assign need_emit = p_valid && (p_fin || (v7 && (s7_live || s7_end)));
  assign q_take    = v7 && (!need_emit || out_free);
  assign emit      = need_emit && out_free;
  assign emit_last = p_fin || !s7_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (emit) begin
      p_valid <= q_take && s7_live;
    end else if (q_take && s7_live) begin
      p_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && s7_live) begin
      p_fin <= s7_end;
      p_req <= s7_req;
    end
  end

  // Held request with its resolved last flag.
  always_comb begin
    out_req      = p_req;
    out_req.last = emit_last;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill.valid <= 1'b0;
    end else if (emit) begin
      fill.valid <= 1'b1;
    end else if (fill.ready) begin
      fill.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fill.payload <= out_req;
    end
  end

`ifndef NO_ASSERTIONS
  a_phys_bound : assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (phys_w <= PW_W'(PHYS_MAX)) && (phys_h <= PW_W'(PHYS_MAX)))
    else $error("physical canvas size above saturation limit");

  a_band_range : assert property (@(posedge clk) disable iff (rst)
    issue |-> piece_idx <= last_idx)
    else $error("band sequencer ran past the last band");

  a_live_cols : assert property (@(posedge clk) disable iff (rst)
    v5 && !s5_empty |-> (s5_cols != '0) && (s5_rows != '0))
    else $error("live band with zero columns or rows");

  a_hold_waits : assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_fin |-> cmd_valid || v1 || v2 || v3 || v4 || v5 || v6 || v7)
    else $error("held band waits with no band of its request in flight");
`endif

endmodule

>>> sim/scaled_rect_fill_stroke_clipper_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the scaled rectangle clipper.
// Draw requests are queued by the stimulus process and pushed into the block by a clocked
// driver that works in bursts. Each accepted draw request is cut into its expected fill
// requests right away. A clocked monitor, which stalls on its own pattern, checks every
// fill request field by field against the oldest outstanding one.
// Canvas registers change only between phases, once the block has gone quiet.
module scaled_rect_fill_stroke_clipper_unit_test;
  import srfc_pkg::*;

  localparam int PHYS_MAX  = 8192;
  localparam int FRAC_BITS = 8;
  // Fraction bits of a scaled coordinate: input fraction plus scale fraction.
  localparam int PT_SHIFT  = FRAC_BITS + SCALE_FRAC;
  // Idle cycles to let pass once nothing is outstanding: lets the pipe run dry
  // of requests that produce no fill request at all.
  localparam int SETTLE    = 32;
  localparam int WD_LIMIT  = 5000;
  localparam int Q_ONE     = 1 << FRAC_BITS;
  localparam int C_MAX     = 8388607;
  localparam int C_MIN     = -8388608;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  srfc_draw_if draw_bus ();
  srfc_fill_if fill_bus ();

  scaled_rect_fill_stroke_clipper_unit #(
    .PHYS_MAX (PHYS_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .draw   (draw_bus),
    .fill   (fill_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the canvas registers, updated as each write lands.
  logic [LOGIC_W-1:0] canvas_w_log;
  logic [LOGIC_W-1:0] canvas_h_log;
  logic [SCALE_W-1:0] canvas_scale;

  draw_req_t draw_backlog[$];   // draw requests not yet offered to the block
  fill_req_t pending_fills[$];  // fill requests the block still owes us

  int burst_left;
  int gap_left;
  int gap_max;
  int stall_run;
  int ready_run;
  int stall_max;
  int bad_fills;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint scale_eff();
    return (canvas_scale == '0) ? longint'(SCALE_ONE) : longint'(canvas_scale);
  endfunction

  // Physical canvas size: floor(logical * scale), saturated at PHYS_MAX.
  function automatic longint canvas_px(input logic [LOGIC_W-1:0] logical_sz);
    longint p;
    p = (longint'(logical_sz) * scale_eff()) >>> SCALE_FRAC;
    return (p > PHYS_MAX) ? longint'(PHYS_MAX) : p;
  endfunction

  // Scale, clip and truncate one logical band; return 1 when a piece survives.
  function automatic bit clip_band(input longint x, input longint y, input longint w,
                                   input longint h, input logic [COLOR_W-1:0] color,
                                   output fill_req_t piece);
    longint s, pw, ph, x1, y1, x2, y2, lim_x, lim_y, idx;
    s     = scale_eff();
    pw    = canvas_px(canvas_w_log);
    ph    = canvas_px(canvas_h_log);
    x1    = x * s;
    y1    = y * s;
    x2    = x1 + w * s;
    y2    = y1 + h * s;
    lim_x = pw <<< PT_SHIFT;
    lim_y = ph <<< PT_SHIFT;
    piece = '0;
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 > lim_x) x2 = lim_x;
    if (y2 > lim_y) y2 = lim_y;
    if (x1 >= x2 || y1 >= y2) return 1'b0;
    // Truncate edges to whole pixels; sub-pixel slivers vanish here.
    x1 = x1 >>> PT_SHIFT;
    y1 = y1 >>> PT_SHIFT;
    x2 = x2 >>> PT_SHIFT;
    y2 = y2 >>> PT_SHIFT;
    if (x2 <= x1 || y2 <= y1) return 1'b0;
    idx               = y1 * pw + x1;
    x2                = x2 - x1;
    y2                = y2 - y1;
    piece.start_index = idx[START_W-1:0];
    piece.row_stride  = pw[STRIDE_W-1:0];
    piece.columns     = x2[CNT_W-1:0];
    piece.rows        = y2[CNT_W-1:0];
    piece.color_out   = color;
    piece.last        = 1'b0;
    return 1'b1;
  endfunction

  // Cut one draw request into the fill requests it must produce, in band order.
  function automatic void cut_pieces(input draw_req_t d);
    fill_req_t pieces[$];
    fill_req_t pc;
    longint x, y, w, h, lw;
    x  = $signed(d.left);
    y  = $signed(d.top);
    w  = $signed(d.span_w);
    h  = $signed(d.span_h);
    lw = $signed(d.stroke_w);
    if (d.op == OP_FILL) begin
      if (clip_band(x, y, w, h, d.fill_color, pc)) pieces.push_back(pc);
    end else if (w > 0 && h > 0 && lw > 0) begin
      // Top and bottom bands always; side bands only when they have height left.
      if (clip_band(x, y, w, lw, d.fill_color, pc)) pieces.push_back(pc);
      if (clip_band(x, y + h - lw, w, lw, d.fill_color, pc)) pieces.push_back(pc);
      if (h > 2 * lw) begin
        if (clip_band(x, y + lw, lw, h - 2 * lw, d.fill_color, pc)) pieces.push_back(pc);
        if (clip_band(x + w - lw, y + lw, lw, h - 2 * lw, d.fill_color, pc))
          pieces.push_back(pc);
      end
    end
    if (pieces.size() > 0) pieces[pieces.size() - 1].last = 1'b1;
    foreach (pieces[i]) pending_fills.push_back(pieces[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_draw(input op_t op, input int l, input int t, input int w,
                            input int h, input int lw, input logic [COLOR_W-1:0] color);
    draw_req_t d;
    d.op         = op;
    d.left       = l[IN_W-1:0];
    d.top        = t[IN_W-1:0];
    d.span_w     = w[IN_W-1:0];
    d.span_h     = h[IN_W-1:0];
    d.stroke_w   = lw[IN_W-1:0];
    d.fill_color = color;
    draw_backlog.push_back(d);
  endtask

  // Coordinate around the logical canvas, with a margin on both sides.
  function automatic int rand_coord(input int span);
    int lo;
    lo = -(span / 4) - 2;
    return lo * Q_ONE + int'($urandom_range(0, (span + span / 2 + 4) * Q_ONE));
  endfunction

  // Size up to about half the canvas; now and then zero or negative.
  function automatic int rand_size(input int span);
    if ($urandom_range(0, 7) == 0) return -int'($urandom_range(0, 2 * Q_ONE));
    return int'($urandom_range(0, (span / 2 + 4) * Q_ONE));
  endfunction

  function automatic draw_req_t rand_draw();
    draw_req_t d;
    int cw, ch, lw, noise;
    cw = int'(canvas_w_log);
    ch = int'(canvas_h_log);
    if ($urandom_range(0, 9) == 0) lw = -int'($urandom_range(0, Q_ONE));
    else lw = int'($urandom_range(1, (ch / 8 + 2) * Q_ONE));
    d.op         = ($urandom_range(0, 1) != 0) ? OP_STROKE : OP_FILL;
    d.left       = IN_W'(rand_coord(cw));
    d.top        = IN_W'(rand_coord(ch));
    d.span_w     = IN_W'(rand_size(cw));
    d.span_h     = IN_W'(rand_size(ch));
    d.stroke_w   = IN_W'(lw);
    d.fill_color = $urandom;
    // Throw in a raw value now and then so every bit, sign bits included, moves.
    noise = $urandom;
    case ($urandom_range(0, 11))
      0: d.left       = noise[IN_W-1:0];
      1: d.top        = noise[IN_W-1:0];
      2: d.span_w     = noise[IN_W-1:0];
      3: d.span_h     = noise[IN_W-1:0];
      4: d.stroke_w   = noise[IN_W-1:0];
      default: ;
    endcase
    return d;
  endfunction

  // APB write: setup cycle, access cycle; junk in the unused upper bits must be ignored.
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] junk;
    logic [APB_DW-1:0] data;
    junk = $urandom;
    if (idx == REG_SCALE_FACTOR) data = {junk[APB_DW-1:SCALE_W], value[SCALE_W-1:0]};
    else data = {junk[APB_DW-1:LOGIC_W], value[LOGIC_W-1:0]};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write has landed at this edge; release the bus.
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOGICAL_WIDTH:  canvas_w_log = value[LOGIC_W-1:0];
      REG_LOGICAL_HEIGHT: canvas_h_log = value[LOGIC_W-1:0];
      REG_SCALE_FACTOR:   canvas_scale = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_canvas(input int w, input int h, input int s);
    reg_write(REG_LOGICAL_WIDTH, w);
    reg_write(REG_LOGICAL_HEIGHT, h);
    reg_write(REG_SCALE_FACTOR, s);
  endtask

  // Hold the sender until every request went in and every fill request came out,
  // then let the pipe run dry.
  task automatic drain();
    do @(negedge clk);
    while (draw_backlog.size() != 0 || draw_bus.valid || pending_fills.size() != 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input int gap, input int stall);
    gap_max   = gap;
    stall_max = stall;
    repeat (n_items) draw_backlog.push_back(rand_draw());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer draw requests in bursts, hold a request until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic      send;
    draw_req_t nxt;
    send = 1'b0;
    nxt  = draw_bus.payload;
    if (!rst) begin
      if (draw_bus.valid && draw_bus.ready) cut_pieces(draw_bus.payload);
      if (draw_bus.valid && !draw_bus.ready) begin
        send = 1'b1;
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (draw_backlog.size() != 0) begin
        nxt  = draw_backlog.pop_front();
        send = 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          // Start a new burst; its gap follows the request that opens it.
          burst_left = $urandom_range(0, 24);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
    end
    draw_bus.valid   <= send;
    draw_bus.payload <= nxt;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each fill request, and drive ready on a run-length pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fill_req_t want;
    fill_req_t got;
    logic      bad;
    logic      take_next;
    if (!rst && fill_bus.valid && fill_bus.ready) begin
      got = fill_bus.payload;
      if (pending_fills.size() == 0) begin
        want = 'x;
        bad  = 1'b1;
      end else begin
        want = pending_fills.pop_front();
        bad  = (got.start_index !== want.start_index) || (got.row_stride !== want.row_stride)
            || (got.columns !== want.columns) || (got.rows !== want.rows)
            || (got.color_out !== want.color_out) || (got.last !== want.last);
      end
      if (bad) begin
        if (bad_fills < 10)
          $display("%0t fill mismatch: want idx=%0d stride=%0d cols=%0d rows=%0d col=%h last=%b",
                   $realtime, want.start_index, want.row_stride, want.columns, want.rows,
                   want.color_out, want.last,
                   "\n                     got  idx=%0d stride=%0d cols=%0d rows=%0d col=%h last=%b",
                   got.start_index, got.row_stride, got.columns, got.rows, got.color_out,
                   got.last);
        bad_fills = bad_fills + 1;
      end
    end
    if (rst) begin
      take_next = 1'b0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
      take_next = 1'b0;
    end else if (ready_run > 0) begin
      ready_run = ready_run - 1;
      take_next = 1'b1;
    end else begin
      ready_run = $urandom_range(1, 12);
      stall_run = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      take_next = 1'b1;
    end
    fill_bus.ready <= take_next;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || psel || (draw_bus.valid && draw_bus.ready) || (fill_bus.valid && fill_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    canvas_w_log     = RST_LOG_WIDTH;
    canvas_h_log     = RST_LOG_HEIGHT;
    canvas_scale     = RST_SCALE;
    gap_max          = 3;
    stall_max        = 3;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests on the reset canvas (640 x 480, scale 1.0).
    queue_draw(OP_FILL, 0, 0, 640 * Q_ONE, 480 * Q_ONE, 0, 32'h0000_0000);
    queue_draw(OP_FILL, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 32'hFFFF_FFFF);
    queue_draw(OP_FILL, 0, 0, C_MAX, C_MAX, C_MAX, 32'h1234_5678);
    queue_draw(OP_FILL, C_MAX, C_MAX, C_MAX, C_MAX, 0, 32'hA5A5_A5A5);
    // Empty pieces: zero and negative sizes, a half-pixel sliver; then one half-offset pixel.
    queue_draw(OP_FILL, 10 * Q_ONE, 20 * Q_ONE, 0, 50 * Q_ONE, 0, 32'h0000_0001);
    queue_draw(OP_FILL, 10 * Q_ONE, 20 * Q_ONE, -5 * Q_ONE, 50 * Q_ONE, 0, 32'h0000_0002);
    queue_draw(OP_FILL, 10 * Q_ONE, 20 * Q_ONE, 50 * Q_ONE, C_MIN, 0, 32'h0000_0003);
    queue_draw(OP_FILL, 0, 0, Q_ONE / 2, Q_ONE, 0, 32'h0000_0004);
    queue_draw(OP_FILL, Q_ONE / 2, 0, Q_ONE, Q_ONE, 0, 32'h8000_0000);
    // Clipped against each edge.
    queue_draw(OP_FILL, 600 * Q_ONE + 128, 470 * Q_ONE + 64, 100 * Q_ONE, 100 * Q_ONE, 0,
               32'h00FF_00FF);
    queue_draw(OP_FILL, -50 * Q_ONE, -30 * Q_ONE, 100 * Q_ONE, 60 * Q_ONE, 0, 32'hFF00_FF00);
    // Strokes: four bands, height exactly twice the line, overlapping bands.
    queue_draw(OP_STROKE, 100 * Q_ONE, 100 * Q_ONE, 200 * Q_ONE, 150 * Q_ONE, 10 * Q_ONE,
               32'hDEAD_BEEF);
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 100 * Q_ONE, 20 * Q_ONE, 10 * Q_ONE,
               32'hCAFE_F00D);
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 100 * Q_ONE, 15 * Q_ONE, 10 * Q_ONE,
               32'h0BAD_F00D);
    // Degenerate strokes: nothing comes out.
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE, 0, 32'h1111_1111);
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE, C_MIN,
               32'h2222_2222);
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 0, 100 * Q_ONE, 5 * Q_ONE, 32'h3333_3333);
    queue_draw(OP_STROKE, 50 * Q_ONE, 50 * Q_ONE, 100 * Q_ONE, -Q_ONE, 5 * Q_ONE,
               32'h4444_4444);
    // Left band falls off the canvas and drops; last stays on the right band.
    queue_draw(OP_STROKE, -10 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE, 5 * Q_ONE,
               32'h5555_5555);
    // Huge stroke: top and bottom bands both cover the canvas.
    queue_draw(OP_STROKE, 0, 0, C_MAX, C_MAX, C_MAX, 32'h6666_6666);
    queue_draw(OP_STROKE, 10 * Q_ONE, 10 * Q_ONE, 20 * Q_ONE, 20 * Q_ONE, C_MAX,
               32'h7777_7777);
    // Fractional edges truncate to whole pixels.
    queue_draw(OP_STROKE, 10 * Q_ONE + 77, 10 * Q_ONE + 179, 50 * Q_ONE + 128,
               40 * Q_ONE + 230, Q_ONE + 128, 32'h9999_9999);
    queue_draw(OP_FILL, 255, 127, 3 * Q_ONE + 255, 2 * Q_ONE + 1, 0, 32'h7FFF_FFFF);

    run_phase(20, 4, 3);

    // Saturated canvas: 8192 x 8192 at the top scale, no idling on either side.
    set_canvas(8192, 8192, 65535);
    run_phase(20, 0, 0);

    // Zero-width canvas with scale zero acting as 1.0: nothing may come out.
    set_canvas(0, 100, 0);
    run_phase(10, 2, 2);

    // Oversized registers at the smallest scale: 63 x 63 pixels, long receiver stalls.
    set_canvas(16383, 16383, 1);
    run_phase(25, 8, 24);

    // Scale 1.5: 150 x 112 pixels.
    set_canvas(100, 75, 384);
    run_phase(25, 3, 6);

    // Scale 0.5 on a tiny canvas: 16 x 8 pixels, heavy clipping.
    set_canvas(33, 17, 128);
    run_phase(25, 0, 12);

    // Scale 2.0: 640 x 480 pixels, sender gaps only.
    set_canvas(320, 240, 512);
    run_phase(25, 6, 0);

    if (bad_fills == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> scaled_rect_fill_stroke_clipper_unit.f
src/srfc_pkg.sv
src/srfc_if.sv
src/scaled_rect_fill_stroke_clipper_unit.sv
sim/scaled_rect_fill_stroke_clipper_unit_test.sv
